// File: sv/hk_pkg.sv
// shared constants, types and command/status structs for the held-karp solver
`timescale 1ns / 1ps
`default_nettype none
package hk_pkg;

  localparam int MAX_NODES_DEF = 12;
  localparam int COST_BITS_DEF = 24;

  // fixed field widths
  localparam int NODE_W  = 4;
  localparam int ECOST_W = 24;
  localparam int TOTAL_W = 32;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [TOTAL_W-1:0] INF = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_NODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_FIXED_END = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_NODE      = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_START = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_END   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_PATH   = 2'd3;

  // controller states, also the command to the datapath
  typedef enum logic [15:0] {
    OP_IDLE    = 16'h0001,
    OP_CHECK   = 16'h0002,
    OP_CLEAR   = 16'h0004,
    OP_INIT    = 16'h0008,
    OP_MASK    = 16'h0010,
    OP_JREAD   = 16'h0020,
    OP_JWAIT   = 16'h0040,
    OP_KREAD   = 16'h0080,
    OP_KEVAL   = 16'h0100,
    OP_FREAD   = 16'h0200,
    OP_FWAIT   = 16'h0400,
    OP_DECIDE  = 16'h0800,
    OP_BREAD   = 16'h1000,
    OP_BWAIT   = 16'h2000,
    OP_EMIT    = 16'h4000,
    OP_EMIT_ST = 16'h8000
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic bad_start;
    logic bad_end;
    logic tail_lock;
    logic clr_last;
    logic mask_done;
    logic has_start;
    logic j_done;
    logic j_in;
    logic here_inf;
    logic k_done;
    logic k_in;
    logic no_path;
    logic pos_zero;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/hk_ctrl.sv
// sequencing state machine for load, check, clear, dp scan, end scan, backtrack and emit
`timescale 1ns / 1ps
`default_nettype none
module hk_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  input  wire hk_pkg::stat_t st,
  output hk_pkg::cmd_t       cmd
);

  hk_pkg::op_t                  state, state_next;
  logic [hk_pkg::STAT_W-1:0]    code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hk_pkg::OP_IDLE;
      code  <= hk_pkg::ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    case (state)
      hk_pkg::OP_IDLE: begin
        if (in_valid && in_last) state_next = hk_pkg::OP_CHECK;
      end
      hk_pkg::OP_CHECK: begin
        if (st.bad_start) begin
          code_next  = hk_pkg::ST_BAD_START;
          state_next = hk_pkg::OP_EMIT_ST;
        end else if (st.bad_end) begin
          code_next  = hk_pkg::ST_BAD_END;
          state_next = hk_pkg::OP_EMIT_ST;
        end else begin
          state_next = hk_pkg::OP_CLEAR;
        end
      end
      hk_pkg::OP_CLEAR:  if (st.clr_last) state_next = hk_pkg::OP_INIT;
      hk_pkg::OP_INIT:   state_next = hk_pkg::OP_MASK;
      hk_pkg::OP_MASK: begin
        if (st.mask_done) state_next = hk_pkg::OP_FREAD;
        else if (st.has_start) state_next = hk_pkg::OP_JREAD;
      end
      hk_pkg::OP_JREAD: begin
        if (st.j_done) state_next = hk_pkg::OP_MASK;
        else if (st.j_in) state_next = hk_pkg::OP_JWAIT;
      end
      hk_pkg::OP_JWAIT: begin
        state_next = st.here_inf ? hk_pkg::OP_JREAD : hk_pkg::OP_KREAD;
      end
      hk_pkg::OP_KREAD: begin
        if (st.k_done) state_next = hk_pkg::OP_JREAD;
        else if (!st.k_in) state_next = hk_pkg::OP_KEVAL;
      end
      hk_pkg::OP_KEVAL:  state_next = hk_pkg::OP_KREAD;
      hk_pkg::OP_FREAD: begin
        if (!st.tail_lock && st.j_done) state_next = hk_pkg::OP_DECIDE;
        else state_next = hk_pkg::OP_FWAIT;
      end
      hk_pkg::OP_FWAIT: begin
        state_next = st.tail_lock ? hk_pkg::OP_DECIDE : hk_pkg::OP_FREAD;
      end
      hk_pkg::OP_DECIDE: begin
        if (st.no_path) begin
          code_next  = hk_pkg::ST_NO_PATH;
          state_next = hk_pkg::OP_EMIT_ST;
        end else begin
          state_next = hk_pkg::OP_BREAD;
        end
      end
      hk_pkg::OP_BREAD: begin
        state_next = st.pos_zero ? hk_pkg::OP_EMIT : hk_pkg::OP_BWAIT;
      end
      hk_pkg::OP_BWAIT:  state_next = hk_pkg::OP_BREAD;
      hk_pkg::OP_EMIT: begin
        if (st.out_free && st.emit_last) state_next = hk_pkg::OP_IDLE;
      end
      hk_pkg::OP_EMIT_ST: begin
        if (st.out_free) state_next = hk_pkg::OP_IDLE;
      end
      default: state_next = hk_pkg::OP_IDLE;
    endcase
  end

  assign in_ready = (state == hk_pkg::OP_IDLE);
  assign cmd.op   = state;
  assign cmd.code = code;

endmodule
`default_nettype wire

// File: sv/hk_dp.sv
// datapath: config registers, cost matrix, dp tables, counters and output register
`timescale 1ns / 1ps
`default_nettype none
module hk_dp #(
  parameter int MAX_NODES = hk_pkg::MAX_NODES_DEF,
  parameter int COST_BITS = hk_pkg::COST_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hk_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                            in_valid,
  input  wire logic [hk_pkg::NODE_W-1:0]       from_node,
  input  wire logic [hk_pkg::NODE_W-1:0]       to_node,
  input  wire logic [hk_pkg::ECOST_W-1:0]      edge_cost,
  input  wire hk_pkg::cmd_t                    cmd,
  output hk_pkg::stat_t                        st,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [hk_pkg::NODE_W-1:0]            path_node,
  output logic [hk_pkg::NODE_W-1:0]            path_position,
  output logic [hk_pkg::TOTAL_W-1:0]           total_cost,
  output logic [hk_pkg::STAT_W-1:0]            status,
  output logic                                 last_result
);

  localparam int IW     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int MW1    = MAX_NODES + 1;
  localparam int BDEPTH = (1 << MAX_NODES) * MAX_NODES;
  localparam int AW     = $clog2(BDEPTH);
  localparam int MDEPTH = MAX_NODES * MAX_NODES;
  localparam int MAW    = $clog2(MDEPTH);
  localparam int TW     = hk_pkg::TOTAL_W;
  localparam int CAND_W = ((COST_BITS > TW) ? COST_BITS : TW) + 1;

  // config
  logic [hk_pkg::CFG_DATA_W-1:0] node_count, start_node, end_node;
  logic                          has_fixed_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= hk_pkg::CFG_DATA_W'(1);
      start_node    <= '0;
      has_fixed_end <= 1'b0;
      end_node      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hk_pkg::REG_NODE_COUNT:    node_count    <= cfg_data;
        hk_pkg::REG_START_NODE:    start_node    <= cfg_data;
        hk_pkg::REG_HAS_FIXED_END: has_fixed_end <= cfg_data[0];
        hk_pkg::REG_END_NODE:      end_node      <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  logic [COST_BITS-1:0] cost_mem [MDEPTH];
  logic [TW-1:0]        best_mem [BDEPTH];
  logic [IW-1:0]        pred_mem [BDEPTH];

  // working registers
  logic [MW1-1:0]   mask;
  logic [CW-1:0]    j, k, pos, r;
  logic [TW-1:0]    here, best;
  logic [IW-1:0]    tail_node, cur;
  logic [MW1-1:0]   bmask;
  logic [IW-1:0]    path [MAX_NODES];

  logic [CW-1:0]    n;
  logic [MW1-1:0]   full;
  logic [IW-1:0]    j_idx, k_idx, s_idx, e_idx;
  logic [MW1-1:0]   nm;

  assign n     = (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);
  assign full  = (MW1'(1) << n) - MW1'(1);
  assign j_idx = IW'(j);
  assign k_idx = IW'(k);
  assign s_idx = IW'(start_node);
  assign e_idx = IW'(end_node);
  assign nm    = mask | (MW1'(1) << k_idx);

  function automatic logic [AW-1:0] baddr(input logic [MW1-1:0] m, input logic [IW-1:0] x);
    baddr = AW'(m[MAX_NODES-1:0]) * AW'(MAX_NODES) + AW'(x);
  endfunction

  // table ports
  logic [AW-1:0]   b_raddr, b_waddr, p_raddr;
  logic [TW-1:0]   b_wdata, b_rdata;
  logic            b_we, p_we;
  logic [IW-1:0]   p_rdata;
  logic [MAW-1:0]  m_raddr, m_waddr;
  logic            m_we;
  logic [COST_BITS-1:0] m_rdata;

  logic [CAND_W-1:0] cand;
  logic [TW-1:0]     cand_sat;
  logic              improve;

  assign cand     = CAND_W'(here) + CAND_W'(m_rdata);
  assign cand_sat = (cand >= CAND_W'(hk_pkg::INF)) ? hk_pkg::INF : TW'(cand);
  assign improve  = cand_sat < b_rdata;

  always_comb begin
    b_raddr = baddr(mask, j_idx);
    case (cmd.op)
      hk_pkg::OP_KREAD, hk_pkg::OP_KEVAL: b_raddr = baddr(nm, k_idx);
      hk_pkg::OP_FREAD: b_raddr = baddr(full, has_fixed_end ? e_idx : j_idx);
      default: ;
    endcase
  end

  always_comb begin
    b_we    = 1'b0;
    b_waddr = baddr(mask, j_idx);
    b_wdata = hk_pkg::INF;
    p_we    = 1'b0;
    case (cmd.op)
      hk_pkg::OP_CLEAR: b_we = 1'b1;
      hk_pkg::OP_INIT: begin
        b_we    = 1'b1;
        b_waddr = baddr(MW1'(1) << s_idx, s_idx);
        b_wdata = '0;
      end
      hk_pkg::OP_KEVAL: begin
        b_we    = improve;
        p_we    = improve;
        b_waddr = baddr(nm, k_idx);
        b_wdata = cand_sat;
      end
      default: ;
    endcase
  end

  assign p_raddr = baddr(bmask, cur);
  assign m_raddr = MAW'(j_idx) * MAW'(MAX_NODES) + MAW'(k_idx);
  assign m_waddr = MAW'(IW'(from_node)) * MAW'(MAX_NODES) + MAW'(IW'(to_node));
  assign m_we    = (cmd.op == hk_pkg::OP_IDLE) && in_valid
                   && (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);

  always_ff @(posedge clk) begin
    if (m_we) cost_mem[m_waddr] <= COST_BITS'(edge_cost);
    m_rdata <= cost_mem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) best_mem[b_waddr] <= b_wdata;
    b_rdata <= best_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) pred_mem[b_waddr] <= j_idx;
    p_rdata <= pred_mem[p_raddr];
  end

  // status to controller
  assign st.bad_start = 32'(start_node) >= 32'(n);
  assign st.bad_end   = has_fixed_end && (32'(end_node) >= 32'(n));
  assign st.tail_lock = has_fixed_end;
  assign st.clr_last  = (mask == full) && (j == CW'(MAX_NODES - 1));
  assign st.mask_done = mask > full;
  assign st.has_start = mask[s_idx];
  assign st.j_done    = j >= n;
  assign st.j_in      = mask[j_idx];
  assign st.here_inf  = b_rdata == hk_pkg::INF;
  assign st.k_done    = k >= n;
  assign st.k_in      = mask[k_idx];
  assign st.no_path   = best == hk_pkg::INF;
  assign st.pos_zero  = pos == '0;
  assign st.emit_last = r == (n - CW'(1));
  assign st.out_free  = !out_valid || out_ready;

  // counters and scan registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      hk_pkg::OP_CHECK: begin
        mask <= '0;
        j    <= '0;
      end
      hk_pkg::OP_CLEAR: begin
        if (j == CW'(MAX_NODES - 1)) begin
          j    <= '0;
          mask <= mask + MW1'(1);
        end else begin
          j <= j + CW'(1);
        end
      end
      hk_pkg::OP_INIT: mask <= '0;
      hk_pkg::OP_MASK: begin
        if (st.mask_done) begin
          j         <= '0;
          best      <= hk_pkg::INF;
          tail_node <= '0;
        end else if (st.has_start) begin
          j <= '0;
        end else begin
          mask <= mask + MW1'(1);
        end
      end
      hk_pkg::OP_JREAD: begin
        if (st.j_done) mask <= mask + MW1'(1);
        else if (!st.j_in) j <= j + CW'(1);
      end
      hk_pkg::OP_JWAIT: begin
        here <= b_rdata;
        if (st.here_inf) j <= j + CW'(1);
        else k <= '0;
      end
      hk_pkg::OP_KREAD: begin
        if (st.k_done) j <= j + CW'(1);
        else if (st.k_in) k <= k + CW'(1);
      end
      hk_pkg::OP_KEVAL: k <= k + CW'(1);
      hk_pkg::OP_FWAIT: begin
        if (has_fixed_end) begin
          best      <= b_rdata;
          tail_node <= e_idx;
        end else begin
          if (b_rdata < best) begin
            best      <= b_rdata;
            tail_node <= j_idx;
          end
          j <= j + CW'(1);
        end
      end
      hk_pkg::OP_DECIDE: begin
        pos   <= n - CW'(1);
        cur   <= tail_node;
        bmask <= full;
        r     <= '0;
      end
      hk_pkg::OP_BREAD: path[IW'(pos)] <= cur;
      hk_pkg::OP_BWAIT: begin
        bmask <= bmask & ~(MW1'(1) << cur);
        cur   <= (32'(p_rdata) < MAX_NODES) ? p_rdata : '0;
        pos   <= pos - CW'(1);
      end
      hk_pkg::OP_EMIT: if (st.out_free) r <= r + CW'(1);
      default: ;
    endcase
  end

  // output register
  logic out_load;
  assign out_load = st.out_free
                    && ((cmd.op == hk_pkg::OP_EMIT) || (cmd.op == hk_pkg::OP_EMIT_ST));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.op == hk_pkg::OP_EMIT) begin
        path_node     <= hk_pkg::NODE_W'(path[IW'(r)]);
        path_position <= hk_pkg::NODE_W'(r);
        total_cost    <= best;
        status        <= hk_pkg::ST_OK;
        last_result   <= st.emit_last;
      end else begin
        path_node     <= '0;
        path_position <= '0;
        total_cost    <= '0;
        status        <= cmd.code;
        last_result   <= 1'b1;
      end
    end
  end

  // an improved entry never stores infinity
  a_no_inf_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == hk_pkg::OP_KEVAL && b_we) |-> (cand_sat != hk_pkg::INF))
    else $error("dp write of infinity");

  // error results always close the solve
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != hk_pkg::ST_OK) |-> last_result)
    else $error("status result not last");

  // a loaded result carries the tour cost, which is finite
  a_cost_finite: assert property (@(posedge clk) disable iff (rst)
    (out_load && cmd.op == hk_pkg::OP_EMIT) |-> (best != hk_pkg::INF))
    else $error("emitting infinite cost");

endmodule
`default_nettype wire

// File: sv/shortest_path_held_karp.sv
// top level of the held-karp shortest hamiltonian path engine
// usage:
//  - config port (cfg_we, cfg_index, cfg_data) sets node_count, start_node,
//    has_fixed_end and end_node; write only while the block is idle
//  - slave stream carries one cost matrix entry per transfer; one entry is
//    taken per cycle while idle; an entry with tlast starts the solve
//  - master stream returns one transfer per path node, each with the total
//    cost, tlast on the final one; a bad setup or no path gives one status
//    transfer instead
// phases:
//  - table clear: every entry up to the full mask, one table entry per cycle
//  - dp scan: each k outside the mask takes a read step and an evaluate step,
//    as the best-cost table has a single read/write port pair
//  - end scan reads every candidate end with an open end, only end_node with a fixed end
//  - backtrack follows the predecessor table to position 0, then one result per cycle while the output register is free
// input is held off (tready low) from the tlast entry until the last result
// is loaded into the output register; a stalled receiver holds results there
// reset clears the config to its defaults and empties the output register;
// the cost matrix holds whatever was last written
`timescale 1ns / 1ps
`default_nettype none
module shortest_path_held_karp #(
  parameter int MAX_NODES = hk_pkg::MAX_NODES_DEF,
  parameter int COST_BITS = hk_pkg::COST_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [hk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [hk_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // from_node[3:0], to_node[7:4], edge_cost[31:8]
  input  wire logic [hk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // path_node[3:0], path_position[7:4], total_cost[39:8], status[41:40], zero pad
  output logic [hk_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic                                    m_axis_tlast
);

  hk_pkg::cmd_t  cmd;
  hk_pkg::stat_t st;

  logic [hk_pkg::NODE_W-1:0]  path_node, path_position;
  logic [hk_pkg::TOTAL_W-1:0] total_cost;
  logic [hk_pkg::STAT_W-1:0]  status;

  // controller sees the transfer only while it is idle and ready
  hk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  hk_dp #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_axis_tvalid),
    .from_node     (s_axis_tdata[3:0]),
    .to_node       (s_axis_tdata[7:4]),
    .edge_cost     (s_axis_tdata[31:8]),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .path_node     (path_node),
    .path_position (path_position),
    .total_cost    (total_cost),
    .status        (status),
    .last_result   (m_axis_tlast)
  );

  // pack result fields, low field first, zero fill to whole bytes
  assign m_axis_tdata = {6'd0, status, total_cost, path_position, path_node};

endmodule
`default_nettype wire
